// File: rtl/imu_time_sync_interpolator_defines.svh
// ----------------------------------------------------------------------------
// imu_time_sync_interpolator_defines
// Assertion macros shared by the interpolator modules.
// ----------------------------------------------------------------------------
`ifndef IMU_TIME_SYNC_INTERPOLATOR_DEFINES_SVH
`define IMU_TIME_SYNC_INTERPOLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/its_pkg.sv
// ----------------------------------------------------------------------------
// its_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int WORDS       = 10;
    localparam int QUAT_BASE   = 6;
    localparam int QUAT_N      = 4;
    localparam int STAMP_W     = 48;
    localparam int DATA_W      = 32;
    localparam int GAP_W       = 24;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int WADDR_W     = $clog2(QUEUE_DEPTH * WORDS);
    localparam int K_W         = $clog2(WORDS);
    localparam int DIV_STEPS   = 33;
    localparam int SQRT_STEPS  = 33;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;
    localparam logic             REG_MAX_GAP = 1'b0;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FEW   = 2'd1;
    localparam status_t STAT_EARLY = 2'd2;
    localparam status_t STAT_GAP   = 2'd3;

    typedef logic [WORDS-1:0][DATA_W-1:0] words_t;

    typedef struct packed {
        logic           load_in;
        logic           push_wr;
        logic           push_commit;
        logic           drop;
        logic           stamp_rd_front;
        logic           stamp_rd_back;
        logic           lat_front_stamp;
        logic           cmp_latch;
        logic           set_status;
        status_t        status_code;
        logic           word_rd_front;
        logic           word_rd_back;
        logic           lat_fv;
        logic           lat_bv;
        logic           mul;
        logic           div_init_interp;
        logic           div_init_norm;
        logic           div_step;
        logic           store_v;
        logic           sq;
        logic           acc;
        logic           sqrt_init;
        logic           sqrt_step;
        logic           store_q;
        logic           out_load;
        logic [K_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic count_lt2;
        logic fgt;
        logic blt;
        logic gapfail;
        logic d_zero;
        logic r_zero;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/its_ram.sv
// ----------------------------------------------------------------------------
// its_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module its_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/its_dp.sv
// ----------------------------------------------------------------------------
// its_dp
// Sample queue, interpolation arithmetic, divider, square root and result
// register of the interpolator.
// ----------------------------------------------------------------------------
`include "imu_time_sync_interpolator_defines.svh"

module its_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  its_pkg::cmd_t                       cmd,
    output its_pkg::sts_t                       sts,
    input  logic [its_pkg::GAP_W-1:0]           max_gap,
    input  logic [its_pkg::STAMP_W-1:0]         in_stamp,
    input  its_pkg::words_t                     in_words,
    output logic                                out_valid,
    input  logic                                out_ready,
    output its_pkg::status_t                    out_status,
    output logic [its_pkg::STAMP_W-1:0]         out_stamp,
    output its_pkg::words_t                     out_words
);

    localparam int SW = its_pkg::SLOT_W;
    localparam int CW = its_pkg::CNT_W;
    localparam int AW = its_pkg::WADDR_W;
    localparam logic [CW:0]   QD_EXT  = (CW + 1)'(its_pkg::QUEUE_DEPTH);
    localparam logic [CW-1:0] QD_CNT  = CW'(its_pkg::QUEUE_DEPTH);
    localparam logic [AW-1:0] WORDS_A = AW'(its_pkg::WORDS);

    function automatic logic [SW-1:0] wrap_slot(input logic [CW:0] s);
        logic [CW:0] t;
        begin
            t = (s >= QD_EXT) ? (s - QD_EXT) : s;
            return t[SW-1:0];
        end
    endfunction

    // Queue state
    logic [SW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    // Captured input item
    logic [its_pkg::STAMP_W-1:0] t_reg;
    its_pkg::words_t             inw_reg;

    // Neighbor stamps and weights
    logic [its_pkg::STAMP_W-1:0] f_reg;
    logic [its_pkg::GAP_W-1:0]   wf_reg;
    logic [its_pkg::GAP_W-1:0]   wb_reg;
    logic [its_pkg::GAP_W:0]     d_reg;
    logic                        dz_reg;

    logic signed [31:0] fv_reg;
    logic signed [31:0] bv_reg;
    logic signed [56:0] pf_reg;
    logic signed [56:0] pb_reg;

    // Shared restoring divider
    logic [32:0] rem_reg;
    logic [32:0] quo_reg;
    logic [32:0] den_reg;
    logic        neg_reg;
    logic        ovf_reg;

    logic [its_pkg::DATA_W-1:0] v_reg [its_pkg::WORDS];

    // Sum of squares and square root
    logic [63:0] sq_reg;
    logic [64:0] n2_reg;
    logic [65:0] sh_reg;
    logic [34:0] srem_reg;
    logic [32:0] root_reg;

    its_pkg::status_t status_reg;
    logic             out_valid_reg;

    logic                        full;
    logic [SW-1:0]               next_slot;
    logic [SW-1:0]               tail_slot;
    logic [AW-1:0]               kext;
    logic [AW-1:0]               fbase;
    logic [AW-1:0]               bbase;
    logic [its_pkg::STAMP_W-1:0] stamp_rdata;
    logic [its_pkg::DATA_W-1:0]  word_rdata;
    logic [its_pkg::STAMP_W-1:0] dwf;
    logic [its_pkg::STAMP_W-1:0] dwb;
    logic [its_pkg::K_W-1:0]     vidx;
    logic signed [31:0]          vv;
    logic signed [57:0]          sum_i;
    logic [57:0]                 mag_i;
    logic [63:0]                 num_i;
    logic [32:0]                 vext;
    logic [32:0]                 vmag;
    logic [63:0]                 num_n;
    logic [33:0]                 dtry;
    logic                        dge;
    logic [36:0]                 stmp;
    logic [36:0]                 strial;
    logic                        sge;
    logic [31:0]                 interp_v;
    logic [31:0]                 norm_q;

    assign full      = (count_reg == QD_CNT);
    assign next_slot = wrap_slot((CW + 1)'(head_reg) + (CW + 1)'(1));
    assign tail_slot = full ? head_reg : wrap_slot((CW + 1)'(head_reg) + (CW + 1)'(count_reg));
    assign kext      = AW'(cmd.k);
    assign fbase     = AW'(head_reg) * WORDS_A;
    assign bbase     = AW'(next_slot) * WORDS_A;

    its_ram #(.WIDTH(its_pkg::STAMP_W), .DEPTH(its_pkg::QUEUE_DEPTH)) u_stamp_ram (
        .clk     (clk),
        .wr_en   (cmd.push_wr),
        .wr_addr (tail_slot),
        .wr_data (t_reg),
        .rd_en   (cmd.stamp_rd_front | cmd.stamp_rd_back),
        .rd_addr (cmd.stamp_rd_back ? next_slot : head_reg),
        .rd_data (stamp_rdata)
    );

    its_ram #(.WIDTH(its_pkg::DATA_W), .DEPTH(its_pkg::QUEUE_DEPTH * its_pkg::WORDS)) u_word_ram (
        .clk     (clk),
        .wr_en   (cmd.push_wr),
        .wr_addr (AW'(tail_slot) * WORDS_A + kext),
        .wr_data (inw_reg[cmd.k]),
        .rd_en   (cmd.word_rd_front | cmd.word_rd_back),
        .rd_addr ((cmd.word_rd_back ? bbase : fbase) + kext),
        .rd_data (word_rdata)
    );

    // Neighbor checks; the back stamp is still on the read port here.
    assign dwf = stamp_rdata - t_reg;
    assign dwb = t_reg - f_reg;

    assign sts.count_lt2 = (count_reg < CW'(2));
    assign sts.fgt       = (f_reg > t_reg);
    assign sts.blt       = (stamp_rdata < t_reg);
    assign sts.gapfail   = (dwf > its_pkg::STAMP_W'(max_gap)) ||
                           (dwb > its_pkg::STAMP_W'(max_gap));
    assign sts.d_zero    = dz_reg;
    assign sts.r_zero    = (root_reg == 33'd0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Interpolation numerator, rounded half away from zero.
    assign sum_i = 58'(pf_reg) + 58'(pb_reg);
    assign mag_i = sum_i[57] ? 58'(-sum_i) : 58'(sum_i);
    assign num_i = 64'(mag_i) + 64'(d_reg >> 1);

    // Normalization numerator c * 2^30 plus half the norm.
    assign vidx  = its_pkg::K_W'(its_pkg::QUAT_BASE) + cmd.k;
    assign vv    = $signed(v_reg[vidx]);
    assign vext  = {vv[31], vv};
    assign vmag  = vv[31] ? (~vext + 33'd1) : vext;
    assign num_n = {1'b0, vmag, 30'd0} + 64'(root_reg >> 1);

    assign dtry = {rem_reg, quo_reg[32]};
    assign dge  = (dtry >= {1'b0, den_reg});

    assign stmp   = {srem_reg, sh_reg[65:64]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign sge    = (stmp >= strial);

    assign interp_v = dz_reg ? fv_reg :
                      (neg_reg ? (~quo_reg[31:0] + 32'd1) : quo_reg[31:0]);

    always_comb
    begin
        if (sts.r_zero)
        begin
            norm_q = 32'd0;
        end
        else if (!neg_reg)
        begin
            norm_q = (ovf_reg || quo_reg >= 33'h080000000) ? 32'h7FFFFFFF : quo_reg[31:0];
        end
        else
        begin
            norm_q = (ovf_reg || quo_reg > 33'h080000000) ? 32'h80000000 :
                     (~quo_reg[31:0] + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= its_pkg::STAT_OK;
        end
        else
        begin
            if (cmd.push_commit)
            begin
                if (full)
                begin
                    head_reg <= next_slot;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (cmd.drop)
            begin
                head_reg  <= next_slot;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            t_reg   <= in_stamp;
            inw_reg <= in_words;
        end
        if (cmd.lat_front_stamp)
        begin
            f_reg <= stamp_rdata;
        end
        if (cmd.cmp_latch)
        begin
            wf_reg <= dwf[its_pkg::GAP_W-1:0];
            wb_reg <= dwb[its_pkg::GAP_W-1:0];
            d_reg  <= (its_pkg::GAP_W + 1)'(dwf[its_pkg::GAP_W-1:0]) +
                      (its_pkg::GAP_W + 1)'(dwb[its_pkg::GAP_W-1:0]);
            dz_reg <= (stamp_rdata == f_reg);
            n2_reg <= '0;
        end
        if (cmd.lat_fv)
        begin
            fv_reg <= $signed(word_rdata);
        end
        if (cmd.lat_bv)
        begin
            bv_reg <= $signed(word_rdata);
        end
        if (cmd.mul)
        begin
            pf_reg <= fv_reg * $signed({1'b0, wf_reg});
            pb_reg <= bv_reg * $signed({1'b0, wb_reg});
        end
        if (cmd.div_init_interp)
        begin
            rem_reg <= {2'b00, num_i[63:33]};
            quo_reg <= num_i[32:0];
            den_reg <= 33'(d_reg);
            neg_reg <= sum_i[57];
            ovf_reg <= 1'b0;
        end
        else if (cmd.div_init_norm)
        begin
            rem_reg <= {2'b00, num_n[63:33]};
            quo_reg <= num_n[32:0];
            den_reg <= root_reg;
            neg_reg <= vv[31];
            ovf_reg <= ({2'b00, num_n[63:33]} >= root_reg);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= dge ? 33'(dtry - {1'b0, den_reg}) : dtry[32:0];
            quo_reg <= {quo_reg[31:0], dge};
        end
        if (cmd.store_v)
        begin
            v_reg[cmd.k] <= interp_v;
        end
        else if (cmd.store_q)
        begin
            v_reg[vidx] <= norm_q;
        end
        if (cmd.sq)
        begin
            sq_reg <= 64'(64'(vv) * 64'(vv));
        end
        if (cmd.acc)
        begin
            n2_reg <= n2_reg + 65'(sq_reg);
        end
        if (cmd.sqrt_init)
        begin
            sh_reg   <= {1'b0, n2_reg};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sh_reg   <= {sh_reg[63:0], 2'b00};
            srem_reg <= sge ? 35'(stmp - strial) : stmp[34:0];
            root_reg <= {root_reg[31:0], sge};
        end
        if (cmd.out_load)
        begin
            out_status <= status_reg;
            out_stamp  <= t_reg;
            for (int i = 0; i < its_pkg::WORDS; i++)
            begin
                out_words[i] <= (status_reg == its_pkg::STAT_OK) ? v_reg[i] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    `ITS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= QD_CNT,
        "queue count exceeds queue depth")
    `ITS_ASSERT_SAME(a_drop_needs_two, clk, rst_n, cmd.drop, count_reg >= CW'(2),
        "sample dropped with fewer than two queued")
    `ITS_ASSERT_SAME(a_load_when_free, clk, rst_n, cmd.out_load,
        !out_valid_reg || out_ready, "result register overwritten before transfer")

endmodule

// File: rtl/its_ctrl.sv
// ----------------------------------------------------------------------------
// its_ctrl
// Sequencer for pushes, queue trimming, interpolation and normalization.
// ----------------------------------------------------------------------------
`include "imu_time_sync_interpolator_defines.svh"

module its_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          req_type,
    input  its_pkg::sts_t sts,
    output its_pkg::cmd_t cmd
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_PUSH   = 20'h00002,
        ST_CHK    = 20'h00004,
        ST_RDF    = 20'h00008,
        ST_CMP    = 20'h00010,
        ST_WRF    = 20'h00020,
        ST_WRB    = 20'h00040,
        ST_WLAT   = 20'h00080,
        ST_MUL    = 20'h00100,
        ST_SUM    = 20'h00200,
        ST_DIV    = 20'h00400,
        ST_WSTORE = 20'h00800,
        ST_SQ     = 20'h01000,
        ST_ACC    = 20'h02000,
        ST_SQI    = 20'h04000,
        ST_SQRT   = 20'h08000,
        ST_NPREP  = 20'h10000,
        ST_NDIV   = 20'h20000,
        ST_NSTORE = 20'h40000,
        ST_DONE   = 20'h80000
    } state_t;

    localparam logic [its_pkg::K_W-1:0]    K_LAST_W  = its_pkg::K_W'(its_pkg::WORDS - 1);
    localparam logic [its_pkg::K_W-1:0]    K_LAST_Q  = its_pkg::K_W'(its_pkg::QUAT_N - 1);
    localparam logic [its_pkg::STEP_W-1:0] DIV_LAST  = its_pkg::STEP_W'(its_pkg::DIV_STEPS - 1);
    localparam logic [its_pkg::STEP_W-1:0] SQRT_LAST = its_pkg::STEP_W'(its_pkg::SQRT_STEPS - 1);

    state_t                    state_reg, state_next;
    logic [its_pkg::K_W-1:0]    k_reg, k_next;
    logic [its_pkg::STEP_W-1:0] step_reg, step_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.k      = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = req_type ? ST_CHK : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push_wr = 1'b1;
                if (k_reg == K_LAST_W)
                begin
                    cmd.push_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_CHK:
            begin
                if (sts.count_lt2)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = its_pkg::STAT_FEW;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.stamp_rd_front = 1'b1;
                    state_next         = ST_RDF;
                end
            end
            ST_RDF:
            begin
                cmd.lat_front_stamp = 1'b1;
                cmd.stamp_rd_back   = 1'b1;
                state_next          = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.set_status = 1'b1;
                if (sts.fgt)
                begin
                    cmd.status_code = its_pkg::STAT_EARLY;
                    state_next      = ST_DONE;
                end
                else if (sts.blt)
                begin
                    // Stale front sample: drop it and look at the next pair.
                    cmd.set_status = 1'b0;
                    cmd.drop       = 1'b1;
                    state_next     = ST_CHK;
                end
                else if (sts.gapfail)
                begin
                    cmd.drop        = 1'b1;
                    cmd.status_code = its_pkg::STAT_GAP;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.status_code = its_pkg::STAT_OK;
                    cmd.cmp_latch   = 1'b1;
                    k_next          = '0;
                    state_next      = ST_WRF;
                end
            end
            ST_WRF:
            begin
                cmd.word_rd_front = 1'b1;
                state_next        = ST_WRB;
            end
            ST_WRB:
            begin
                cmd.word_rd_back = 1'b1;
                cmd.lat_fv       = 1'b1;
                state_next       = ST_WLAT;
            end
            ST_WLAT:
            begin
                cmd.lat_bv = 1'b1;
                state_next = sts.d_zero ? ST_WSTORE : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.div_init_interp = 1'b1;
                step_next           = '0;
                state_next          = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_WSTORE;
                end
            end
            ST_WSTORE:
            begin
                cmd.store_v = 1'b1;
                if (k_reg == K_LAST_W)
                begin
                    k_next     = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_WRF;
                end
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (k_reg == K_LAST_Q)
                begin
                    k_next     = '0;
                    state_next = ST_SQI;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_NPREP;
                end
            end
            ST_NPREP:
            begin
                if (sts.r_zero)
                begin
                    state_next = ST_NSTORE;
                end
                else
                begin
                    cmd.div_init_norm = 1'b1;
                    step_next         = '0;
                    state_next        = ST_NDIV;
                end
            end
            ST_NDIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_NSTORE;
                end
            end
            ST_NSTORE:
            begin
                cmd.store_q = 1'b1;
                if (k_reg == K_LAST_Q)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_NPREP;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

    `ITS_ASSERT_NEXT(a_sync_starts_check, clk, rst_n,
        (state_reg == ST_IDLE) && in_valid && req_type, state_reg == ST_CHK,
        "accepted sync request did not start the queue check")

endmodule

// File: rtl/imu_time_sync_interpolator.sv
// ----------------------------------------------------------------------------
// imu_time_sync_interpolator: IMU sample queue with timed linear interpolation.
// A push writes the stamp and words into the queue. A sync drops stale samples,
// then interpolates (33-step shared divider per channel, 33-step square root).
// rst_n clears queue head and count, controller and result valid; max_gap -> GAP_RESET.
// ----------------------------------------------------------------------------
module imu_time_sync_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [47:0]         stamp,
    input  logic signed [31:0]  acc_x,
    input  logic signed [31:0]  acc_y,
    input  logic signed [31:0]  acc_z,
    input  logic signed [31:0]  gyro_x,
    input  logic signed [31:0]  gyro_y,
    input  logic signed [31:0]  gyro_z,
    input  logic signed [31:0]  quat_x,
    input  logic signed [31:0]  quat_y,
    input  logic signed [31:0]  quat_z,
    input  logic signed [31:0]  quat_w,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [47:0]         sync_stamp,
    output logic signed [31:0]  out_acc_x,
    output logic signed [31:0]  out_acc_y,
    output logic signed [31:0]  out_acc_z,
    output logic signed [31:0]  out_gyro_x,
    output logic signed [31:0]  out_gyro_y,
    output logic signed [31:0]  out_gyro_z,
    output logic signed [31:0]  out_quat_x,
    output logic signed [31:0]  out_quat_y,
    output logic signed [31:0]  out_quat_z,
    output logic signed [31:0]  out_quat_w
);

    logic [its_pkg::GAP_W-1:0] max_gap_reg;
    logic                      gap_sel;
    its_pkg::cmd_t             cmd;
    its_pkg::sts_t             sts;
    its_pkg::words_t           in_words;
    its_pkg::words_t           out_words;

    assign pready  = 1'b1;
    assign gap_sel = (paddr[2] == its_pkg::REG_MAX_GAP);
    assign prdata  = gap_sel ? 32'(max_gap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg <= its_pkg::GAP_RESET;
        end
        else if (psel && penable && pwrite && pready && gap_sel)
        begin
            max_gap_reg <= pwdata[its_pkg::GAP_W-1:0];
        end
    end

    assign in_words[0] = acc_x;
    assign in_words[1] = acc_y;
    assign in_words[2] = acc_z;
    assign in_words[3] = gyro_x;
    assign in_words[4] = gyro_y;
    assign in_words[5] = gyro_z;
    assign in_words[6] = quat_x;
    assign in_words[7] = quat_y;
    assign in_words[8] = quat_z;
    assign in_words[9] = quat_w;

    its_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    its_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .max_gap    (max_gap_reg),
        .in_stamp   (stamp),
        .in_words   (in_words),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_status (status),
        .out_stamp  (sync_stamp),
        .out_words  (out_words)
    );

    assign out_acc_x  = out_words[0];
    assign out_acc_y  = out_words[1];
    assign out_acc_z  = out_words[2];
    assign out_gyro_x = out_words[3];
    assign out_gyro_y = out_words[4];
    assign out_gyro_z = out_words[5];
    assign out_quat_x = out_words[6];
    assign out_quat_y = out_words[7];
    assign out_quat_z = out_words[8];
    assign out_quat_w = out_words[9];

endmodule
